FILE: design/mcst_pkg.sv
package mcst_pkg;

   localparam int MaxChannels = 16;
   localparam int ChanWidth   = 4;
   localparam int ValueWidth  = 16;

   typedef enum logic [1:0] {
      MODE_TICK    = 2'd0,
      MODE_ASSIGN  = 2'd1,
      MODE_ENABLE  = 2'd2,
      MODE_DISABLE = 2'd3
   } mode_type;

   // Per-channel control for one word, decoded by the top level.
   typedef struct packed {
      logic                    tick;
      logic                    load;
      logic                    start;
      logic                    stop;
      logic [ValueWidth-1:0]   interval;
   } chan_ctrl_type;

endpackage

FILE: design/mcst_channel.sv
module mcst_channel (
   input  logic                   clock,
   input  logic                   reset,
   input  mcst_pkg::chan_ctrl_type ctrl,
   output logic                   fire
);
   import mcst_pkg::*;

   logic [ValueWidth-1:0] count_ff, count_in;
   logic [ValueWidth-1:0] interval_ff, interval_in;
   logic                  active_ff, active_in;
   logic                  assigned_ff, assigned_in;
   logic                  hit;

   assign hit  = (count_ff == interval_ff);
   assign fire = ctrl.tick & active_ff & assigned_ff & hit;

   always_comb begin
      count_in    = count_ff;
      interval_in = interval_ff;
      active_in   = active_ff;
      assigned_in = assigned_ff;
      if (ctrl.tick) begin
         if (active_ff && assigned_ff) begin
            count_in = hit ? '0 : count_ff + 1'b1;
         end
      end else if (ctrl.load) begin
         interval_in = ctrl.interval;
         count_in    = '0;
         active_in   = 1'b1;
         assigned_in = 1'b1;
      end else if (ctrl.start) begin
         count_in  = '0;
         active_in = 1'b1;
      end else if (ctrl.stop) begin
         active_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         interval_ff <= '0;
         active_ff   <= 1'b0;
         assigned_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         interval_ff <= interval_in;
         active_ff   <= active_in;
         assigned_ff <= assigned_in;
      end
   end

endmodule

FILE: design/multi_channel_soft_timer.sv
// Channel   Direction  Handshake            Payload
// req       in         req_tvalid/tready    tdata: channel, interval; tuser: mode
// rsp       out        rsp_tvalid/tready    tdata: fire_mask
// csr       in         csr_we               csr_wdata: prescale_period
//
// Every request word yields one response word, registered in the input register
// and then in the response register. While no response stall holds it, one word
// is taken per cycle; all channels compare and update in parallel between them.
// A stalled response holds both stages; the input register still takes a word
// while the response register is full but the input stage is empty.
// Synchronous reset: prescale period to one; count, channels, pipeline cleared.
module multi_channel_soft_timer #(
   parameter int NUM_CHANNELS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [3:0] channel, [19:4] interval, [23:20] zero
   input  logic [1:0]  req_tuser,   // [1:0] mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] fire_mask
   input  logic        csr_we,
   input  logic [15:0] csr_wdata
);
   import mcst_pkg::*;

   localparam logic [ChanWidth:0] NumCh = (ChanWidth+1)'(NUM_CHANNELS);

   logic                  stall;
   logic                  s1_valid_ff, s1_valid_in;
   mode_type              s1_mode_ff;
   logic [ChanWidth-1:0]  s1_chan_ff;
   logic [ValueWidth-1:0] s1_interval_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ValueWidth-1:0] rsp_mask_ff;
   logic [ValueWidth-1:0] period_ff;
   logic [ValueWidth-1:0] pcount_ff, pcount_in, pcount_inc;
   logic                  process;
   logic                  is_tick, is_assign, is_enable, is_disable;
   logic                  chan_ok;
   logic                  ptick;
   logic [NUM_CHANNELS-1:0] fire;
   logic [ValueWidth-1:0] mask;
   chan_ctrl_type         ctrl [NUM_CHANNELS];

   assign stall       = rsp_valid_ff & ~rsp_tready;
   assign req_tready  = ~s1_valid_ff | ~stall;
   assign process     = s1_valid_ff & ~stall;
   assign s1_valid_in = (s1_valid_ff & stall) | (req_tvalid & req_tready);
   assign rsp_valid_in = stall | s1_valid_ff;

   always_comb begin
      is_tick    = 1'b0;
      is_assign  = 1'b0;
      is_enable  = 1'b0;
      is_disable = 1'b0;
      unique case (s1_mode_ff)
         MODE_TICK:    is_tick    = 1'b1;
         MODE_ASSIGN:  is_assign  = 1'b1;
         MODE_ENABLE:  is_enable  = 1'b1;
         MODE_DISABLE: is_disable = 1'b1;
         default:      is_tick    = 1'b0;
      endcase
   end

   assign chan_ok    = {1'b0, s1_chan_ff} < NumCh;
   assign pcount_inc = pcount_ff + 1'b1;
   assign ptick      = process & is_tick & (pcount_inc == period_ff);

   always_comb begin
      pcount_in = pcount_ff;
      if (process && is_tick) begin
         pcount_in = ptick ? '0 : pcount_inc;
      end
   end

   genvar i;
   generate
      for (i = 0; i < NUM_CHANNELS; i++) begin : g_chan
         logic sel;
         assign sel = process & chan_ok & (s1_chan_ff == ChanWidth'(i));
         assign ctrl[i].tick     = ptick;
         assign ctrl[i].load     = sel & is_assign;
         assign ctrl[i].start    = sel & is_enable;
         assign ctrl[i].stop     = sel & is_disable;
         assign ctrl[i].interval = s1_interval_ff;

         mcst_channel u_channel (
            .clock (clock),
            .reset (reset),
            .ctrl  (ctrl[i]),
            .fire  (fire[i])
         );
      end
   endgenerate

   assign mask      = ValueWidth'(fire);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_mask_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         period_ff    <= 16'd1;
         pcount_ff    <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         pcount_ff    <= pcount_in;
         if (csr_we) begin
            period_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_mode_ff     <= mode_type'(req_tuser);
         s1_chan_ff     <= req_tdata[ChanWidth-1:0];
         s1_interval_ff <= req_tdata[ChanWidth+ValueWidth-1:ChanWidth];
      end
      if (process) begin
         rsp_mask_ff <= mask;
      end
   end

endmodule

FILE: tb/tb_multi_channel_soft_timer.sv
`timescale 1ns / 100ps

module tb_multi_channel_soft_timer;
   import mcst_pkg::*;

   localparam int NumChannels = MaxChannels;
   localparam int HoldCycles  = 400;
   localparam int CycleLimit  = 3_000_000;
   localparam int MaxPrinted  = 20;

   typedef struct packed {
      mode_type              mode;
      logic [ChanWidth-1:0]  chan;
      logic [ValueWidth-1:0] ivl;
      logic                  has_want;
      logic [ValueWidth-1:0] want_mask;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;   // [3:0] channel, [19:4] interval, [23:20] zero
   logic [1:0]  req_tuser;   // [1:0] mode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;   // [15:0] fire_mask
   logic        csr_we;
   logic [15:0] csr_wdata;

   // Timer state as the block should hold it.
   logic [ValueWidth-1:0] presc_period;
   logic [ValueWidth-1:0] presc_count;
   logic [ValueWidth-1:0] ch_count    [NumChannels];
   logic [ValueWidth-1:0] ch_interval [NumChannels];
   logic                  ch_active   [NumChannels];
   logic                  ch_assigned [NumChannels];

   logic [ValueWidth-1:0] fire_mask_q [$];
   stim_row_type          table_want_q [$];
   stim_row_type          directed_rows [25];

   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int hold_requests = 0;
   int holds_taken = 0;
   int hold_left = 0;
   int error_count = 0;
   int words_checked = 0;
   int prescale_writes = 0;
   int cycle_count = 0;
   logic [ValueWidth-1:0] want_word;
   stim_row_type          want_row;

   multi_channel_soft_timer #(
      .NUM_CHANNELS(NumChannels)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("Timeout after %0d cycles with %0d words outstanding",
                  cycle_count, fire_mask_q.size());
         $display("Verification failed");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      error_count++;
      if (error_count <= MaxPrinted)
         $display("MISMATCH %s: got %h, expected %h (cycle %0d)", what, got, want,
                  cycle_count);
   endtask

   // Applies one request word to the timer state and returns the channels that fire.
   function automatic logic [ValueWidth-1:0] timer_advance(input mode_type m,
         input logic [ChanWidth-1:0] ch, input logic [ValueWidth-1:0] ivl);
      logic [ValueWidth-1:0] mask;
      mask = '0;
      if (m == MODE_TICK) begin
         presc_count = presc_count + 16'd1;
         if (presc_count == presc_period) begin
            presc_count = '0;
            for (int n = 0; n < NumChannels; n++) begin
               if (ch_active[n] && ch_assigned[n]) begin
                  if (ch_count[n] == ch_interval[n]) begin
                     ch_count[n] = '0;
                     mask[n] = 1'b1;
                  end else begin
                     ch_count[n] = ch_count[n] + 16'd1;
                  end
               end
            end
         end
      end else if (int'(ch) < NumChannels) begin
         case (m)
            MODE_ASSIGN: begin
               ch_interval[ch] = ivl;
               ch_count[ch]    = '0;
               ch_active[ch]   = 1'b1;
               ch_assigned[ch] = 1'b1;
            end
            MODE_ENABLE: begin
               ch_active[ch] = 1'b1;
               ch_count[ch]  = '0;
            end
            default: ch_active[ch] = 1'b0;
         endcase
      end
      return mask;
   endfunction

   // Follows accepted words and register writes on the bus itself.
   always @(posedge clock) begin
      if (reset) begin
         presc_period = 16'd1;
         presc_count  = '0;
         for (int n = 0; n < NumChannels; n++) begin
            ch_count[n]    = '0;
            ch_interval[n] = '0;
            ch_active[n]   = 1'b0;
            ch_assigned[n] = 1'b0;
         end
      end else begin
         if (csr_we)
            presc_period = csr_wdata;
         if (req_tvalid && req_tready)
            fire_mask_q.push_back(timer_advance(mode_type'(req_tuser), req_tdata[3:0],
                                                req_tdata[19:4]));
      end
   end

   // Response side: check each word, then decide the next ready.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (fire_mask_q.size() == 0) begin
            report_mismatch("response word with nothing expected", rsp_tdata, 16'h0);
         end else begin
            want_word = fire_mask_q.pop_front();
            words_checked++;
            if (rsp_tdata !== want_word)
               report_mismatch("fire_mask", rsp_tdata, want_word);
            if (table_want_q.size() != 0) begin
               want_row = table_want_q.pop_front();
               if (want_row.has_want && rsp_tdata !== want_row.want_mask)
                  report_mismatch("fire_mask of directed word", rsp_tdata,
                                  want_row.want_mask);
            end
         end
      end
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else if (holds_taken != hold_requests) begin
         holds_taken++;
         hold_left = HoldCycles;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // Called right after a rising edge; returns at the edge that accepts the word.
   task automatic send_word(input mode_type m, input logic [ChanWidth-1:0] ch,
                            input logic [ValueWidth-1:0] ivl);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= m;
      req_tdata  <= {4'd0, ivl, ch};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
   endtask

   task automatic send_random_word();
      int pick;
      logic [ValueWidth-1:0] ivl;
      pick = $urandom_range(99);
      ivl  = ($urandom_range(99) < 80) ? 16'($urandom_range(0, 7)) : 16'($urandom());
      if (pick < 55)
         send_word(MODE_TICK, 4'($urandom()), 16'($urandom()));
      else if (pick < 70)
         send_word(MODE_ASSIGN, 4'($urandom()), ivl);
      else if (pick < 85)
         send_word(MODE_ENABLE, 4'($urandom()), 16'($urandom()));
      else
         send_word(MODE_DISABLE, 4'($urandom()), 16'($urandom()));
   endtask

   task automatic send_ticks(input int count);
      repeat (count)
         send_word(MODE_TICK, 4'($urandom()), 16'($urandom()));
   endtask

   // The last accepted word is pushed at its own edge, so look only after that.
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      repeat (2) @(posedge clock);
      while (fire_mask_q.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_prescale(input logic [15:0] value);
      drain_responses();
      repeat (3) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      prescale_writes++;
      @(posedge clock);
   endtask

   initial begin
      logic [15:0] periods [4];
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = MODE_TICK;
      csr_we     = 1'b0;
      csr_wdata  = '0;

      // Reset leaves the prescaler at one, so every tick here is a channel tick.
      directed_rows = '{
         '{MODE_TICK,    4'd0,  16'h0000, 1'b1, 16'h0000},
         '{MODE_ASSIGN,  4'd0,  16'h0000, 1'b1, 16'h0000},
         '{MODE_TICK,    4'd0,  16'hFFFF, 1'b1, 16'h0001},
         '{MODE_ASSIGN,  4'd15, 16'h0001, 1'b1, 16'h0000},
         '{MODE_TICK,    4'd0,  16'h0000, 1'b1, 16'h0001},
         '{MODE_TICK,    4'd0,  16'h0000, 1'b1, 16'h8001},
         '{MODE_ENABLE,  4'd3,  16'hFFFF, 1'b1, 16'h0000},
         '{MODE_TICK,    4'd0,  16'h0000, 1'b1, 16'h0001},
         '{MODE_TICK,    4'd0,  16'h0000, 1'b1, 16'h8001},
         '{MODE_DISABLE, 4'd0,  16'h0000, 1'b1, 16'h0000},
         '{MODE_TICK,    4'd0,  16'h0000, 1'b1, 16'h0000},
         '{MODE_ENABLE,  4'd0,  16'h0000, 1'b1, 16'h0000},
         '{MODE_TICK,    4'd0,  16'h0000, 1'b1, 16'h8001},
         '{MODE_ASSIGN,  4'd7,  16'hFFFF, 1'b1, 16'h0000},
         '{MODE_DISABLE, 4'd9,  16'h0000, 1'b1, 16'h0000},
         '{MODE_TICK,    4'd0,  16'h0000, 1'b0, 16'h0000},
         '{MODE_DISABLE, 4'd15, 16'h0000, 1'b1, 16'h0000},
         '{MODE_TICK,    4'd0,  16'h0000, 1'b0, 16'h0000},
         '{MODE_ASSIGN,  4'd3,  16'h0002, 1'b1, 16'h0000},
         '{MODE_TICK,    4'd0,  16'h0000, 1'b0, 16'h0000},
         '{MODE_TICK,    4'd0,  16'h0000, 1'b0, 16'h0000},
         '{MODE_ENABLE,  4'd15, 16'hAAAA, 1'b1, 16'h0000},
         '{MODE_TICK,    4'd0,  16'h0000, 1'b0, 16'h0000},
         '{MODE_DISABLE, 4'd0,  16'h5555, 1'b1, 16'h0000},
         '{MODE_TICK,    4'd0,  16'h0000, 1'b0, 16'h0000}
      };

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      tx_idle_pct = 30;
      rx_idle_pct = 59;
      foreach (directed_rows[i]) begin
         table_want_q.push_back(directed_rows[i]);
         send_word(directed_rows[i].mode, directed_rows[i].chan, directed_rows[i].ivl);
      end

      for (int ph = 0; ph < 3; ph++) begin
         case (ph)
            0: begin
               tx_idle_pct = 30;
               rx_idle_pct = 59;
            end
            1: begin
               tx_idle_pct = 59;
               rx_idle_pct = 30;
            end
            default: begin
               tx_idle_pct = 0;
               rx_idle_pct = 0;
            end
         endcase
         periods = '{16'd1, 16'd2, 16'd3, 16'($urandom_range(4, 9))};
         foreach (periods[k]) begin
            write_prescale(periods[k]);
            // A long receiver stall while words keep coming fills the pipeline.
            if (ph < 2 && k == 1)
               hold_requests++;
            repeat (140) send_random_word();
         end
      end

      // Prescaler extremes: a period of zero or of the top value holds off every
      // channel tick, and lowering the period below the current count waits too.
      send_word(MODE_ASSIGN, 4'd1, 16'h0000);
      send_word(MODE_ASSIGN, 4'd2, 16'h0001);
      send_word(MODE_ASSIGN, 4'd4, 16'hFFFF);
      write_prescale(16'h0000);
      send_ticks(40);
      write_prescale(16'hFFFF);
      send_ticks(40);
      write_prescale(16'd2);
      send_ticks(40);
      write_prescale(16'd1);
      repeat (100) send_random_word();

      drain_responses();
      repeat (10) @(posedge clock);
      if (fire_mask_q.size() != 0)
         report_mismatch("expected words never arrived", 16'h0, fire_mask_q[0]);

      $display("Checked %0d response words over %0d prescaler settings,",
               words_checked, prescale_writes);
      $display("with idle sender and receiver, long stalls and prescaler extremes.");
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Mismatches: %0d", error_count);
         $display("Verification failed");
      end
      $finish;
   end

endmodule

FILE: filelist.f
design/mcst_pkg.sv
design/mcst_channel.sv
design/multi_channel_soft_timer.sv
tb/tb_multi_channel_soft_timer.sv
